// ===== hw/rtl/bisp_pkg.sv =====
package bisp_pkg;

  localparam int GroupsDefault = 32;
  localparam int GroupBits     = 32;
  localparam int GroupShift    = 5;
  localparam int BitIdxW       = 5;
  localparam int ValueW        = 10;
  localparam int CountW        = 11;
  localparam int ReqTypeW      = 2;
  localparam int StatusW       = 2;

  localparam logic [ReqTypeW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqTypeW-1:0] REQ_TEST   = 2'd1;
  localparam logic [ReqTypeW-1:0] REQ_POP    = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [ReqTypeW-1:0] req_type;
    logic [ValueW-1:0]   value;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [ValueW-1:0]   popped_value;
    logic [StatusW-1:0]  status;
    logic [CountW-1:0]   member_count;
  } rsp_t;

  typedef struct packed {
    logic set;
    logic clr;
  } sum_upd_t;

  function automatic logic [BitIdxW-1:0] low_bit_index(input logic [GroupBits-1:0] w);
    logic [BitIdxW-1:0] idx;
    idx = '0;
    for (int i = GroupBits - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BitIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/bisp_req_if.sv =====
interface bisp_req_if;
  logic           valid;
  logic           ready;
  bisp_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bisp_rsp_if.sv =====
interface bisp_rsp_if;
  logic           valid;
  logic           ready;
  bisp_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bisp_ram.sv =====
module bisp_ram #(
  parameter int Width = 32,
  parameter int Depth = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/bisp_summary.sv =====
module bisp_summary #(
  parameter int Groups = bisp_pkg::GroupsDefault,
  localparam int GrpW = (Groups > 1) ? $clog2(Groups) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bisp_pkg::sum_upd_t upd_i,
  input  logic [GrpW-1:0]    grp_i,
  output logic [Groups-1:0]  bits_o,
  output logic               any_o,
  output logic [GrpW-1:0]    first_o
);

  logic [Groups-1:0] bits_q, bits_d;

  always_comb begin
    bits_d = bits_q;
    if (upd_i.set) begin
      bits_d[grp_i] = 1'b1;
    end
    if (upd_i.clr) begin
      bits_d[grp_i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

  // lowest non-empty group
  always_comb begin
    first_o = '0;
    for (int i = Groups - 1; i >= 0; i--) begin
      if (bits_q[i]) begin
        first_o = GrpW'(i);
      end
    end
  end

  assign bits_o = bits_q;
  assign any_o  = |bits_q;

endmodule

// ===== hw/rtl/bitmap_integer_set_pop_min.sv =====
// Bitmap set of integers in 0 .. Groups*32-1, empty after reset. Each request inserts a value
// (hit when newly added), tests membership, or pops the smallest member; every request gives
// one response carrying the member count after it. Values beyond the set's range report
// status 2, a pop on an empty set status 1. The group word is read from the group memory in
// the cycle of acceptance and written back once the response register is free; no new request
// is taken until that write-back. A pop finds its group by priority encoding a one-bit-per-group
// summary register, which also marks which memory words hold data, so no clearing pass is
// needed after reset.
module bitmap_integer_set_pop_min #(
  parameter int Groups = bisp_pkg::GroupsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bisp_req_if.sink   req_i,
  bisp_rsp_if.source rsp_o
);

  localparam int GrpW     = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int Universe = Groups * bisp_pkg::GroupBits;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [bisp_pkg::ReqTypeW-1:0] req_q;
  logic [bisp_pkg::BitIdxW-1:0]  bit_q;
  logic [GrpW-1:0]               grp_q, rd_grp, ram_raddr;
  logic                          range_q, empty_q;
  logic [bisp_pkg::CountW-1:0]   count_q, count_d;
  logic                          out_valid_q;
  bisp_pkg::rsp_t                out_q, out_d;

  logic [Groups-1:0]               sum_bits;
  logic                            sum_any;
  logic [GrpW-1:0]                 sum_first;
  bisp_pkg::sum_upd_t              sum_upd;
  logic [bisp_pkg::GroupBits-1:0]  ram_rdata, data, mask, flag, wdata;
  logic                            we, in_range, accept, out_free, exec_fire, present;

  assign in_range  = 32'(req_i.payload.value) < 32'(Universe);
  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign exec_fire = (state_q == S_EXEC) && out_free;
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    if (req_i.payload.req_type == bisp_pkg::REQ_POP) begin
      rd_grp = sum_first;
    end else if (in_range) begin
      rd_grp = GrpW'(req_i.payload.value >> bisp_pkg::GroupShift);
    end else begin
      rd_grp = '0;
    end
  end

  // hold the read on the captured group while the response stalls
  assign ram_raddr = (state_q == S_EXEC) ? grp_q : rd_grp;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_i.payload.req_type;
      bit_q   <= req_i.payload.value[bisp_pkg::BitIdxW-1:0];
      grp_q   <= rd_grp;
      range_q <= in_range;
      empty_q <= !sum_any;
    end
  end

  // words of empty groups are stale: read them as zero
  assign data    = sum_bits[grp_q] ? ram_rdata : '0;
  assign mask    = bisp_pkg::GroupBits'(1) << bit_q;
  assign present = |(data & mask);
  assign flag    = data & (~data + bisp_pkg::GroupBits'(1));

  always_comb begin
    we            = 1'b0;
    wdata         = data;
    sum_upd       = '0;
    count_d       = count_q;
    out_d         = '0;
    out_d.status  = bisp_pkg::STATUS_OK;
    unique case (req_q)
      bisp_pkg::REQ_INSERT: begin
        if (!range_q) begin
          out_d.status = bisp_pkg::STATUS_RANGE;
        end else if (!present) begin
          we          = 1'b1;
          wdata       = data | mask;
          sum_upd.set = 1'b1;
          count_d     = count_q + bisp_pkg::CountW'(1);
          out_d.hit   = 1'b1;
        end
      end
      bisp_pkg::REQ_TEST: begin
        if (!range_q) begin
          out_d.status = bisp_pkg::STATUS_RANGE;
        end else begin
          out_d.hit = present;
        end
      end
      bisp_pkg::REQ_POP: begin
        if (empty_q) begin
          out_d.status = bisp_pkg::STATUS_EMPTY;
        end else begin
          we                 = 1'b1;
          wdata              = data & ~flag;
          sum_upd.clr        = ~|(data & ~flag);
          out_d.hit          = 1'b1;
          out_d.popped_value = bisp_pkg::ValueW'((32'(grp_q) << bisp_pkg::GroupShift)
                               | 32'(bisp_pkg::low_bit_index(flag)));
          if (count_q != '0) begin
            count_d = count_q - bisp_pkg::CountW'(1);
          end
        end
      end
      default: ;
    endcase
    out_d.member_count = count_d;
  end

  bisp_summary #(.Groups(Groups)) u_summary (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (exec_fire ? sum_upd : '0),
    .grp_i   (grp_q),
    .bits_o  (sum_bits),
    .any_o   (sum_any),
    .first_o (sum_first)
  );

  bisp_ram #(.Width(bisp_pkg::GroupBits), .Depth(Groups)) u_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && we),
    .waddr_i (grp_q),
    .wdata_i (wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule

// ===== hw/rtl/bisp_chk.sv =====
module bisp_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input bisp_pkg::rsp_t rsp_i
);

  a_popped_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_i.hit |-> rsp_i.popped_value == '0)
    else $error("popped value without a hit");

  a_error_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.status != bisp_pkg::STATUS_OK |-> !rsp_i.hit)
    else $error("hit reported with error status");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.status == bisp_pkg::STATUS_EMPTY |-> rsp_i.member_count == '0)
    else $error("empty pop with non-zero count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("transaction taken while previous one in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled response changed");

endmodule

bind bitmap_integer_set_pop_min bisp_chk u_bisp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);
